>>> src/q8bd_pkg.sv
// Shared types, constants and floating-point helper functions for the
// quantized block dot-product row accumulator. No dependencies.
`default_nettype none

package q8bd_pkg;

  localparam int unsigned MaxBlocksDefault = 128;
  localparam int unsigned BlockLen = 32;
  localparam int unsigned BlockBits = BlockLen * 8;

  localparam logic [31:0] ActScaleReset = 32'h3F80_0000;
  localparam logic [7:0] BlocksPerRowReset = 8'd1;
  localparam logic [31:0] CanonNan = 32'h7FC0_0000;

  // Configuration register indexes.
  localparam logic CfgActScale = 1'b0;
  localparam logic CfgBlocksPerRow = 1'b1;

  // Input opcodes.
  localparam logic OpLoad = 1'b0;
  localparam logic OpWeight = 1'b1;

  typedef enum logic {
    FPU_MUL,
    FPU_ADD
  } fpu_op_e;

  typedef enum logic {
    MUL_SCALE,
    MUL_TERM
  } mul_sel_e;

  // Unpacked operand: value is man * 2^(exp - 150), man need not be normalized.
  typedef struct packed {
    logic       sgn;
    logic [7:0] exp;
    logic [23:0] man;
    logic       zero;
    logic       inf;
    logic       nan;
  } fp_op_t;

  typedef struct packed {
    logic     act_wr;
    logic     blk_load;
    logic     prod_en;
    logic     dot_en;
    logic     fpu_issue;
    fpu_op_e  fpu_op;
    mul_sel_e mul_sel;
    logic     commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_block;
  } ctrl_sts_t;

  function automatic fp_op_t unpack_single(input logic [31:0] x);
    fp_op_t r;
    r.sgn  = x[31];
    r.exp  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    r.man  = {(x[30:23] != 8'd0), x[22:0]};
    r.zero = (x[30:0] == 31'd0);
    r.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    r.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    return r;
  endfunction

  // Half precision operand, exact: subnormals keep an unnormalized mantissa.
  function automatic fp_op_t unpack_half(input logic [15:0] h);
    fp_op_t r;
    r.sgn  = h[15];
    r.exp  = (h[14:10] == 5'd0) ? 8'd126 : (8'(h[14:10]) + 8'd125);
    r.man  = (h[14:10] == 5'd0) ? {14'd0, h[9:0]} : {13'd0, 1'b1, h[9:0]};
    r.zero = (h[14:0] == 15'd0);
    r.inf  = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
    r.nan  = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
    return r;
  endfunction

  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [6:0] cnt;
    logic       found;
    cnt = 7'd64;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && v[i]) begin
        cnt = 7'(63 - i);
        found = 1'b1;
      end
    end
    return cnt;
  endfunction

  // Normalize and round to nearest even. A leading one at bit 63 of n stands
  // for 1.f * 2^(e - 127).
  function automatic logic [31:0] norm_round(input logic sgn, input logic signed [11:0] e,
                                             input logic [63:0] n);
    logic [6:0]          lz;
    logic [63:0]         nn;
    logic signed [11:0]  er;
    logic signed [11:0]  sh;
    logic [6:0]          shc;
    logic [127:0]        wide;
    logic [63:0]         nr;
    logic                lost;
    logic                rnd;
    logic [7:0]          ef;
    logic [31:0]         mag;
    logic [31:0]         res;
    lz   = lzc64(n);
    nn   = n << lz;
    er   = e - $signed({5'd0, lz});
    sh   = 12'sd1 - er;
    shc  = (sh > 12'sd64) ? 7'd64 : sh[6:0];
    wide = {nn, 64'd0} >> shc;
    if (er <= 12'sd0) begin
      nr   = wide[127:64];
      lost = |wide[63:0];
      ef   = 8'd0;
    end else begin
      nr   = nn;
      lost = 1'b0;
      ef   = er[7:0];
    end
    rnd = nr[39] & ((|nr[38:0]) | lost | nr[40]);
    mag = {1'b0, ef, nr[62:40]} + 32'(rnd);
    if (n == 64'd0) begin
      res = {sgn, 31'd0};
    end else if (er >= 12'sd255) begin
      res = {sgn, 8'hFF, 23'd0};
    end else begin
      res = {sgn, mag[30:0]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> src/q8_block_dot_row_accumulator.sv
// Top level of the quantized block dot-product row accumulator.
// Depends on q8bd_pkg, q8bd_ctrl and q8bd_datapath.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   opcode, block_index, block_scale, packed bytes
//   out      output     out_valid_o / out_ready_i row_sum, row_number
//   cfg      input      cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// An activation load writes the block into the activation memory at the transfer
// edge. A weight block is not taken until the one before it has been committed,
// after its chain through the shared two-stage fp unit: scale multiply, term
// multiply and accumulate, each issued once the one before has its result.
// A finished row sum waits in an output register; the next item is still taken,
// and only a row end that finds that register still full holds the block.
// Reset clears the accumulator, counters and handshake state; the activation
// memory is undefined until written.
`default_nettype none

module q8_block_dot_row_accumulator
  import q8bd_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MaxBlocksDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        opcode_i,
  input  wire logic [6:0]  block_index_i,
  input  wire logic [15:0] block_scale_i,
  input  wire logic [63:0] packed_bytes_0_i,
  input  wire logic [63:0] packed_bytes_1_i,
  input  wire logic [63:0] packed_bytes_2_i,
  input  wire logic [63:0] packed_bytes_3_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      row_sum_o,
  output logic [15:0]      row_number_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  logic [31:0] act_scale_q;
  logic [7:0]  blocks_per_row_q;
  ctrl_cmd_t   cmd;
  ctrl_sts_t   sts;

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_scale_q      <= ActScaleReset;
      blocks_per_row_q <= BlocksPerRowReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgActScale:     act_scale_q      <= cfg_data_i;
        CfgBlocksPerRow: blocks_per_row_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  q8bd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (opcode_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Byte j of the block sits at bits 8j of the concatenated packed fields.
  q8bd_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .act_scale_i      (act_scale_q),
    .blocks_per_row_i (blocks_per_row_q),
    .block_index_i    (block_index_i),
    .block_scale_i    (block_scale_i),
    .bytes_i          ({packed_bytes_3_i, packed_bytes_2_i,
                        packed_bytes_1_i, packed_bytes_0_i}),
    .row_sum_o        (row_sum_o),
    .row_number_o     (row_number_o)
  );

endmodule

`default_nettype wire

>>> src/q8bd_fpu.sv
// Two-stage binary32 multiply/add unit with round to nearest even.
// Depends on q8bd_pkg for operand types and the normalize/round function.
`default_nettype none

module q8bd_fpu
  import q8bd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        issue_i,
  input  wire fpu_op_e     op_i,
  input  wire fp_op_t      mul_a_i,
  input  wire fp_op_t      mul_b_i,
  input  wire logic [31:0] add_a_i,
  input  wire logic [31:0] add_b_i,
  output logic [31:0]      res_o
);

  logic               s1_vld_q;
  logic               s1_sgn_q, s1_sgn_d;
  logic signed [11:0] s1_e_q, s1_e_d;
  logic [63:0]        s1_n_q, s1_n_d;
  logic               s1_nan_q, s1_nan_d;
  logic               s1_inf_q, s1_inf_d;
  logic [31:0]        res_q, res_d;

  fp_op_t       ua, ub, big, sml;
  logic [7:0]   d;
  logic [63:0]  na, nb;
  logic [127:0] wide;
  logic [63:0]  nbj;
  logic [63:0]  sum;
  logic [47:0]  prod;

  always_comb begin
    ua    = unpack_single(add_a_i);
    ub    = unpack_single(add_b_i);
    big   = (add_b_i[30:0] > add_a_i[30:0]) ? ub : ua;
    sml   = (add_b_i[30:0] > add_a_i[30:0]) ? ua : ub;
    d     = big.exp - sml.exp;
    na    = {1'b0, big.man, 39'd0};
    nb    = {1'b0, sml.man, 39'd0};
    wide  = {nb, 64'd0} >> d;
    nbj   = wide[127:64] | {63'd0, |wide[63:0]};
    sum   = (big.sgn == sml.sgn) ? (na + nbj) : (na - nbj);
    prod  = mul_a_i.man * mul_b_i.man;

    unique case (op_i)
      FPU_MUL: begin
        s1_sgn_d = mul_a_i.sgn ^ mul_b_i.sgn;
        s1_e_d   = $signed({4'd0, mul_a_i.exp}) + $signed({4'd0, mul_b_i.exp}) - 12'sd126;
        s1_n_d   = {prod, 16'd0};
        s1_nan_d = mul_a_i.nan | mul_b_i.nan | (mul_a_i.inf & mul_b_i.zero) |
                   (mul_b_i.inf & mul_a_i.zero);
        s1_inf_d = mul_a_i.inf | mul_b_i.inf;
      end
      FPU_ADD: begin
        s1_sgn_d = ua.inf ? ua.sgn :
                   ub.inf ? ub.sgn :
                   (sum == 64'd0) ? (ua.sgn & ub.sgn) : big.sgn;
        s1_e_d   = $signed({4'd0, big.exp}) + 12'sd1;
        s1_n_d   = sum;
        s1_nan_d = ua.nan | ub.nan | (ua.inf & ub.inf & (ua.sgn != ub.sgn));
        s1_inf_d = ua.inf | ub.inf;
      end
      default: begin
        s1_sgn_d = 1'b0;
        s1_e_d   = 12'sd0;
        s1_n_d   = 64'd0;
        s1_nan_d = 1'b0;
        s1_inf_d = 1'b0;
      end
    endcase

    if (s1_nan_q) begin
      res_d = CanonNan;
    end else if (s1_inf_q) begin
      res_d = {s1_sgn_q, 8'hFF, 23'd0};
    end else begin
      res_d = norm_round(s1_sgn_q, s1_e_q, s1_n_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      s1_sgn_q <= s1_sgn_d;
      s1_e_q   <= s1_e_d;
      s1_n_q   <= s1_n_d;
      s1_nan_q <= s1_nan_d;
      s1_inf_q <= s1_inf_d;
    end
    if (s1_vld_q) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

>>> src/q8bd_datapath.sv
// Datapath: activation memory, 32 product lanes, dot sum, fp unit, row state.
// Depends on q8bd_pkg and q8bd_fpu.
`default_nettype none

module q8bd_datapath
  import q8bd_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MaxBlocksDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ctrl_cmd_t   cmd_i,
  output ctrl_sts_t        sts_o,
  input  wire logic [31:0] act_scale_i,
  input  wire logic [7:0]  blocks_per_row_i,
  input  wire logic [6:0]  block_index_i,
  input  wire logic [15:0] block_scale_i,
  input  wire logic [BlockBits-1:0] bytes_i,
  output logic [31:0]      row_sum_o,
  output logic [15:0]      row_number_o
);

  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned LW = ((CW > 8) ? CW : 8) + 1;
  localparam int unsigned XW = ((AW > 7) ? AW : 7) + 1;

  logic [BlockBits-1:0] act_mem [MAX_BLOCKS];
  logic [BlockBits-1:0] act_rd_q;
  logic [BlockBits-1:0] wgt_q;
  logic [15:0]          hscale_q;
  logic signed [15:0]   prod_q [BlockLen];
  logic signed [20:0]   dot_q, dot_d;
  logic [31:0]          acc_q;
  logic [AW-1:0]        blk_cnt_q;
  logic [15:0]          row_cnt_q;
  logic [31:0]          row_sum_q;
  logic [15:0]          row_number_q;

  logic [XW-1:0] idx_x;
  logic          wr_ok;
  logic [LW-1:0] bpr_x, bpr_eff, cnt_next;
  logic [20:0]   dot_abs;
  fp_op_t        mul_a, mul_b, dot_op;
  logic [31:0]   fpu_res;

  assign idx_x = XW'(block_index_i);
  assign wr_ok = idx_x < XW'(MAX_BLOCKS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.act_wr && wr_ok) begin
      act_mem[idx_x[AW-1:0]] <= bytes_i;
    end
    if (cmd_i.blk_load) begin
      act_rd_q <= act_mem[blk_cnt_q];
      wgt_q    <= bytes_i;
      hscale_q <= block_scale_i;
    end
  end

  // Activation bytes carry an offset of 128: flipping the top bit gives a-128.
  for (genvar j = 0; j < BlockLen; j++) begin : g_lane
    logic signed [7:0] a_s, w_s;
    assign a_s = $signed({~act_rd_q[8*j+7], act_rd_q[8*j+:7]});
    assign w_s = $signed(wgt_q[8*j+:8]);
    always_ff @(posedge clk_i) begin
      if (cmd_i.prod_en) begin
        prod_q[j] <= a_s * w_s;
      end
    end
  end

  always_comb begin
    dot_d = 21'sd0;
    for (int j = 0; j < BlockLen; j++) begin
      dot_d = dot_d + 21'(prod_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dot_en) begin
      dot_q <= dot_d;
    end
  end

  // The integer dot product enters the multiplier exactly, unnormalized.
  always_comb begin
    dot_abs     = dot_q[20] ? 21'(-dot_q) : dot_q;
    dot_op.sgn  = dot_q[20];
    dot_op.exp  = 8'd150;
    dot_op.man  = 24'(dot_abs);
    dot_op.zero = (dot_q == 21'sd0);
    dot_op.inf  = 1'b0;
    dot_op.nan  = 1'b0;
    unique case (cmd_i.mul_sel)
      MUL_SCALE: begin
        mul_a = unpack_half(hscale_q);
        mul_b = unpack_single(act_scale_i);
      end
      MUL_TERM: begin
        mul_a = unpack_single(fpu_res);
        mul_b = dot_op;
      end
      default: begin
        mul_a = dot_op;
        mul_b = dot_op;
      end
    endcase
  end

  q8bd_fpu u_fpu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (cmd_i.fpu_issue),
    .op_i    (cmd_i.fpu_op),
    .mul_a_i (mul_a),
    .mul_b_i (mul_b),
    .add_a_i (acc_q),
    .add_b_i (fpu_res),
    .res_o   (fpu_res)
  );

  // Row length: zero acts as one, large values clamp to the store depth.
  always_comb begin
    bpr_x    = LW'(blocks_per_row_i);
    bpr_eff  = (bpr_x == '0) ? LW'(1) :
               (bpr_x > LW'(MAX_BLOCKS)) ? LW'(MAX_BLOCKS) : bpr_x;
    cnt_next = LW'(blk_cnt_q) + LW'(1);
  end

  assign sts_o.last_block = (cnt_next >= bpr_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= 32'd0;
      blk_cnt_q <= '0;
      row_cnt_q <= 16'd0;
    end else if (cmd_i.commit) begin
      if (sts_o.last_block) begin
        acc_q     <= 32'd0;
        blk_cnt_q <= '0;
        row_cnt_q <= row_cnt_q + 16'd1;
      end else begin
        acc_q     <= fpu_res;
        blk_cnt_q <= blk_cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && sts_o.last_block) begin
      row_sum_q    <= fpu_res;
      row_number_q <= row_cnt_q;
    end
  end

  assign row_sum_o    = row_sum_q;
  assign row_number_o = row_number_q;

endmodule

`default_nettype wire

>>> src/q8bd_ctrl.sv
// Controller state machine that sequences one weight block through the datapath.
// Depends on q8bd_pkg for the command and status structs.
`default_nettype none

module q8bd_ctrl
  import q8bd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic opcode_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_SUM,
    ST_MUL,
    ST_MUL_WAIT,
    ST_ADD,
    ST_ADD_WAIT,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_commit;

  assign can_commit = !sts_i.last_block || !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o       = '0;
    cmd_o.fpu_op  = FPU_MUL;
    cmd_o.mul_sel = MUL_SCALE;
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (opcode_i == OpWeight) begin
            cmd_o.blk_load = 1'b1;
            state_d = ST_PROD;
          end else begin
            cmd_o.act_wr = 1'b1;
          end
        end
      end
      ST_PROD: begin
        cmd_o.prod_en   = 1'b1;
        cmd_o.fpu_issue = 1'b1;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.dot_en = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.fpu_issue = 1'b1;
        cmd_o.mul_sel   = MUL_TERM;
        state_d = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.fpu_issue = 1'b1;
        cmd_o.fpu_op    = FPU_ADD;
        state_d = ST_ADD_WAIT;
      end
      ST_ADD_WAIT: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (can_commit) begin
          cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
          if (sts_i.last_block) begin
            out_valid_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> tb/sv/q8bd_row_checker.sv
// Scoreboard for the quantized block dot-product row accumulator: watches the
// input, output and register-write ports, predicts each row sum in software
// binary32 arithmetic and checks it and its row number. Depends on q8bd_pkg.
module q8bd_row_checker
  import q8bd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        opcode_i,
  input  logic [6:0]  block_index_i,
  input  logic [15:0] block_scale_i,
  input  logic [63:0] packed_bytes_0_i,
  input  logic [63:0] packed_bytes_1_i,
  input  logic [63:0] packed_bytes_2_i,
  input  logic [63:0] packed_bytes_3_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] row_sum_i,
  input  logic [15:0] row_number_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] sum;
    logic [15:0] num;
  } row_result_t;

  logic [255:0] act_mem [MaxBlocksDefault];
  logic [31:0]  row_acc;
  logic [31:0]  act_scale;
  logic [7:0]   row_len;
  int unsigned  block_cnt;
  logic [15:0]  row_cnt;
  row_result_t  rows_due[$];

  function automatic bit is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 0);
  endfunction

  function automatic bit is_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 0);
  endfunction

  // Value is m * 2^e2.
  function automatic void split_fp(input logic [31:0] x, output int e2,
                                   output logic [63:0] m);
    if (x[30:23] == 0) begin
      e2 = -149;
      m = 64'(x[22:0]);
    end else begin
      e2 = int'(x[30:23]) - 150;
      m = 64'({1'b1, x[22:0]});
    end
  endfunction

  // Rounds the exact value m * 2^e2 to binary32, nearest even.
  function automatic logic [31:0] fp_round(input logic s, input int e2, input logic [63:0] m);
    int p;
    int bexp;
    int ulp;
    int sh;
    logic [127:0] w;
    logic [63:0] q;
    logic [63:0] r;
    longint tot;
    if (m == 0) return {s, 31'd0};
    p = 63;
    while (!m[p]) p--;
    bexp = p + e2 + 127;
    if (bexp >= 255) return {s, 8'hFF, 23'd0};
    ulp = (bexp >= 1) ? (p + e2 - 23) : -149;
    sh = ulp - e2;
    if (sh <= 0) begin
      q = m << (-sh);
    end else if (sh >= 128) begin
      q = 0;
    end else begin
      w = {m, 64'd0} >> sh;
      q = w[127:64];
      r = w[63:0];
      if (r[63] && ((r[62:0] != 0) || q[0])) q++;
    end
    tot = (longint'((bexp >= 1) ? bexp : 1) - 1) * 64'd8388608 + longint'(q);
    if (tot >= 64'h7F80_0000) return {s, 8'hFF, 23'd0};
    return {s, tot[30:0]};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    int ea;
    int eb;
    logic [63:0] ma;
    logic [63:0] mb;
    logic s;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return CanonNan;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 0 || b[30:0] == 0) return CanonNan;
      return {s, 8'hFF, 23'd0};
    end
    if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
    split_fp(a, ea, ma);
    split_fp(b, eb, mb);
    return fp_round(s, ea + eb, ma * mb);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    int ea;
    int eb;
    int d;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] big;
    logic [63:0] sml;
    logic [63:0] t;
    logic [63:0] m;
    logic s;
    logic [31:0] x;
    if (is_nan(a) || is_nan(b)) return CanonNan;
    if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : CanonNan;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
    if (a[30:0] == 0) return b;
    if (b[30:0] == 0) return a;
    split_fp(a, ea, ma);
    split_fp(b, eb, mb);
    if (ea < eb) begin
      x = a; a = b; b = x;
      split_fp(a, ea, ma);
      split_fp(b, eb, mb);
    end
    d = ea - eb;
    big = ma << 32;
    t = mb << 32;
    // Bits shifted out are jammed into the lowest bit; 32 guard bits keep it exact.
    if (d >= 64) sml = (mb != 0);
    else sml = (t >> d) | ((d > 0) && ((t & ((64'd1 << d) - 1)) != 0));
    if (a[31] == b[31]) begin
      m = big + sml;
      s = a[31];
    end else if (big >= sml) begin
      m = big - sml;
      s = a[31];
    end else begin
      m = sml - big;
      s = b[31];
    end
    if (m == 0) return 32'd0;
    return fp_round(s, ea - 32, m);
  endfunction

  function automatic logic [31:0] half_to_fp32(input logic [15:0] h);
    logic [31:0] e;
    logic [31:0] f;
    logic [31:0] ex;
    e = 32'(h[14:10]);
    f = 32'(h[9:0]);
    if (e == 0) begin
      if (f == 0) return {h[15], 31'd0};
      ex = 113;
      while ((f & 32'h400) == 0) begin
        f = f << 1;
        ex--;
      end
      return {h[15], ex[7:0], f[9:0], 13'd0};
    end
    if (e == 32'h1F) return {h[15], 8'hFF, f[9:0], 13'd0};
    return {h[15], 8'(e + 112), f[9:0], 13'd0};
  endfunction

  task automatic accumulate_block(input logic [15:0] hscale, input logic [255:0] wts);
    int dot;
    int eff_len;
    logic [255:0] acts;
    logic [31:0] term;
    row_result_t res;
    dot = 0;
    acts = act_mem[block_cnt % MaxBlocksDefault];
    for (int j = 0; j < BlockLen; j++) begin
      dot += (int'(acts[8*j +: 8]) - 128) * int'($signed(wts[8*j +: 8]));
    end
    term = fp_mul(half_to_fp32(hscale), act_scale);
    term = fp_mul(term, fp_round(dot < 0, 0, 64'(dot < 0 ? -dot : dot)));
    row_acc = fp_add(row_acc, term);
    if (is_nan(row_acc)) row_acc = CanonNan;
    eff_len = (row_len == 0) ? 1 : ((row_len > MaxBlocksDefault) ? MaxBlocksDefault : row_len);
    if (block_cnt + 1 >= eff_len) begin
      res.sum = row_acc;
      res.num = row_cnt;
      rows_due.push_back(res);
      row_cnt++;
      row_acc = 0;
      block_cnt = 0;
    end else begin
      block_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    row_result_t exp_row;
    if (!rst_ni) begin
      row_acc = 0;
      act_scale = ActScaleReset;
      row_len = BlocksPerRowReset;
      block_cnt = 0;
      row_cnt = 0;
      rows_due.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgActScale) act_scale = cfg_data_i;
        else row_len = cfg_data_i[7:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (rows_due.size() == 0) begin
          $display("%0t: unexpected row result sum %h row %0d", $time, row_sum_i,
                   row_number_i);
          errors_o++;
        end else begin
          exp_row = rows_due.pop_front();
          if (row_sum_i !== exp_row.sum) begin
            $display("%0t: row_sum expected %h actual %h", $time, exp_row.sum, row_sum_i);
            errors_o++;
          end
          if (row_number_i !== exp_row.num) begin
            $display("%0t: row_number expected %0d actual %0d", $time, exp_row.num,
                     row_number_i);
            errors_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (opcode_i == OpLoad) begin
          act_mem[block_index_i] = {packed_bytes_3_i, packed_bytes_2_i, packed_bytes_1_i,
                                    packed_bytes_0_i};
        end else begin
          accumulate_block(block_scale_i, {packed_bytes_3_i, packed_bytes_2_i,
                                           packed_bytes_1_i, packed_bytes_0_i});
        end
      end
    end
    pending_o = rows_due.size();
  end

endmodule

>>> tb/sv/tb_q8_block_dot_row_accumulator.sv
// Testbench top for the quantized block dot-product row accumulator: drives
// phases of register settings and block traffic, and gives the verdict.
// Depends on q8bd_pkg, the block itself and q8bd_row_checker.
module tb_q8_block_dot_row_accumulator;
  import q8bd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int HoldOffCycles = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        opcode_i = OpLoad;
  logic [6:0]  block_index_i = '0;
  logic [15:0] block_scale_i = '0;
  logic [63:0] packed_bytes_0_i = '0;
  logic [63:0] packed_bytes_1_i = '0;
  logic [63:0] packed_bytes_2_i = '0;
  logic [63:0] packed_bytes_3_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] row_sum_o;
  logic [15:0] row_number_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = CfgActScale;
  logic [31:0] cfg_data_i = '0;

  int errors;
  int rows_pending;
  int cycles = 0;

  // Stimulus-side view of the row position, so that a weight block never
  // pairs with an activation slot that was never loaded.
  bit [MaxBlocksDefault-1:0] slot_loaded = '0;
  int row_pos = 0;
  int row_len_eff = 1;

  // Set once by the stimulus to ask the receiver for its long hold-off.
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  always #1 clk_i = ~clk_i;

  q8_block_dot_row_accumulator dut (.*);

  q8bd_row_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .opcode_i, .block_index_i,
    .block_scale_i, .packed_bytes_0_i, .packed_bytes_1_i, .packed_bytes_2_i,
    .packed_bytes_3_i, .out_valid_i(out_valid_o), .out_ready_i, .row_sum_i(row_sum_o),
    .row_number_i(row_number_o), .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(rows_pending)
  );

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request so that the
  // output register stays full and the block has to stall its input.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        gap = pick_gap();
        out_ready_i <= (gap == 0);
        @(posedge clk_i);
      end
    end
  end

  function automatic logic [63:0] pick_lane();
    unique case ($urandom_range(0, 9))
      0: return {8{8'h80}};
      1: return {8{8'h7F}};
      2: return {8{8'h00}};
      3: return {8{8'hFF}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Half scales: mostly moderate values so sums stay finite, plus the full
  // range and the zero, subnormal, infinity and NaN encodings.
  function automatic logic [15:0] pick_scale();
    logic [15:0] specials [10];
    int sel;
    specials = '{16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h7C00, 16'hFC00, 16'h7E00,
                 16'h7C01, 16'h7BFF, 16'h3C00};
    sel = $urandom_range(0, 9);
    if (sel < 6) return {1'($urandom), 5'($urandom_range(10, 20)), 10'($urandom)};
    if (sel < 9) return 16'($urandom);
    return specials[$urandom_range(0, 9)];
  endfunction

  // One transfer on the input channel, after an optional idle gap. The valid
  // is only lowered for a gap before an item, so it stays high between back-to-back items.
  task automatic send_item(input logic op, input logic [6:0] idx, input logic [15:0] hs,
                           input logic [63:0] b0, input logic [63:0] b1,
                           input logic [63:0] b2, input logic [63:0] b3, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    opcode_i <= op;
    block_index_i <= idx;
    block_scale_i <= hs;
    packed_bytes_0_i <= b0;
    packed_bytes_1_i <= b1;
    packed_bytes_2_i <= b2;
    packed_bytes_3_i <= b3;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (op == OpLoad) begin
      slot_loaded[idx] = 1'b1;
    end else if (row_pos + 1 >= row_len_eff) begin
      row_pos = 0;
    end else begin
      row_pos++;
    end
  endtask

  task automatic load_block(input logic [6:0] idx, input int gap);
    send_item(OpLoad, idx, 16'($urandom), pick_lane(), pick_lane(), pick_lane(), pick_lane(),
              gap);
  endtask

  // Weight block with random content; loads the slot it will read first if needed.
  task automatic weight_block(input logic [15:0] hs, input int gap);
    if (!slot_loaded[row_pos]) load_block(7'(row_pos), pick_gap());
    send_item(OpWeight, 7'($urandom), hs, pick_lane(), pick_lane(), pick_lane(), pick_lane(),
              gap);
  endtask

  // Registers change only once every row result is out and the block has had
  // time to finish any block still in flight.
  task automatic configure(input logic [31:0] scale, input logic [7:0] len);
    in_valid_i <= 1'b0;
    while (rows_pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CfgActScale;
    cfg_data_i <= scale;
    @(posedge clk_i);
    cfg_index_i <= CfgBlocksPerRow;
    cfg_data_i <= {24'($urandom), len};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    row_len_eff = (len == 0) ? 1 : ((len > MaxBlocksDefault) ? MaxBlocksDefault : len);
  endtask

  task automatic random_phase(input int count, input bit quiet_sender);
    for (int n = 0; n < count; n++) begin
      if (quiet_sender && n == count / 2 && !hold_done) hold_req = 1'b1;
      if ($urandom_range(0, 9) < 2) load_block(7'($urandom), quiet_sender ? 0 : pick_gap());
      else weight_block(pick_scale(), quiet_sender ? 0 : pick_gap());
    end
  endtask

  initial begin
    logic [15:0] scale_list [9];
    scale_list = '{16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h7C00, 16'hFC00, 16'h7E00,
                   16'h7BFF, 16'h3C00};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme bytes, the special scales, the top slot, and a load
    // with an unused scale field.
    configure(ActScaleReset, 8'd1);
    send_item(OpLoad, 7'd0, 16'hFFFF, '0, '0, '0, '0, 0);
    send_item(OpLoad, 7'd127, 16'h0000, '1, '1, '1, '1, 0);
    send_item(OpWeight, 7'd127, 16'h3C00, 64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080,
              64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080, 0);
    send_item(OpWeight, 7'd0, 16'h7BFF, 64'h7F7F_7F7F_7F7F_7F7F, 64'h7F7F_7F7F_7F7F_7F7F,
              64'h7F7F_7F7F_7F7F_7F7F, 64'h7F7F_7F7F_7F7F_7F7F, 0);
    foreach (scale_list[i]) weight_block(scale_list[i], 0);
    random_phase(80, 1'b0);

    configure({1'b0, 8'($urandom_range(110, 140)), 23'($urandom)}, 8'd3);
    random_phase(100, 1'b0);

    // The sender keeps offering items while the receiver holds off.
    configure(ActScaleReset, 8'd1);
    random_phase(150, 1'b1);

    configure(32'h0000_0001, 8'd2);
    random_phase(50, 1'b0);
    configure(32'h7F7F_FFFF, 8'd0);
    random_phase(50, 1'b0);
    configure({1'b1, 8'($urandom_range(100, 127)), 23'($urandom)}, 8'd255);
    random_phase(120, 1'b0);
    configure(32'h7F80_0000, 8'd128);
    random_phase(130, 1'b0);
    configure(32'h7FC0_0001, 8'd4);
    random_phase(30, 1'b0);

    in_valid_i <= 1'b0;
    while (rows_pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/q8bd_pkg.sv
src/q8bd_fpu.sv
src/q8bd_datapath.sv
src/q8bd_ctrl.sv
src/q8_block_dot_row_accumulator.sv
tb/sv/q8bd_row_checker.sv
tb/sv/tb_q8_block_dot_row_accumulator.sv
